/* rtl/lcsw_pkg.sv */
// Shared constants, types and helpers for the load cell step weigher.
`default_nettype none

package lcsw_pkg;

   // Sample and filter geometry
   localparam int SAMPLE_W    = 24;
   localparam logic [SAMPLE_W-1:0] SIGN_FLIP = 24'h800000;
   localparam int FILTER_TAPS = 16;
   localparam int TAP_PTR_W   = $clog2(FILTER_TAPS);
   localparam int TAP_SUM_W   = SAMPLE_W + TAP_PTR_W;

   // Capture length default (top-level parameter default)
   localparam int CAPTURE_SAMPLES = 10;

   // Weight arithmetic
   localparam int GAIN_W     = 24;
   localparam int OFFSET_W   = 25;
   localparam int WEIGHT_W   = 32;
   localparam int GAIN_SHIFT = 16;
   localparam int PRODUCT_W  = GAIN_W + SAMPLE_W;
   localparam int SCALED_W   = PRODUCT_W - GAIN_SHIFT;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 32'h7FFF_FFFF;

   // Register file
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 25;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_GAIN    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_OFFSET  = 2'd2;

   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 24'd8000;
   localparam logic [GAIN_W-1:0]   GAIN_RESET      = 24'd1335970;
   // -700.3 * 256 in two's complement
   localparam logic [OFFSET_W-1:0] OFFSET_RESET    = 25'h1FD43B3;

   // What travels with a request down the pipeline
   typedef struct packed {
      logic                weighed;
      logic [SAMPLE_W-1:0] filtered;
      logic [SAMPLE_W-1:0] change;
      logic [SAMPLE_W-1:0] baseline;
   } lcsw_info_type;

   function automatic logic [SAMPLE_W-1:0] abs_diff(input logic [SAMPLE_W-1:0] a,
                                                    input logic [SAMPLE_W-1:0] b);
      logic [SAMPLE_W-1:0] d;
      if (a >= b) begin
         d = a - b;
      end else begin
         d = b - a;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

/* rtl/lcsw_filter.sv */
// Moving average filter, step trigger and capture accumulator (first stage).
`default_nettype none

module lcsw_filter #(
   parameter int  CAPTURE_SAMPLES = lcsw_pkg::CAPTURE_SAMPLES,
   localparam int CAP_LEFT_W      = $clog2(CAPTURE_SAMPLES + 1),
   localparam int CAP_SUM_W       = lcsw_pkg::SAMPLE_W + CAP_LEFT_W
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            advance,
   input  wire logic                            accept,
   input  wire logic [lcsw_pkg::SAMPLE_W-1:0]   raw_sample,
   input  wire logic [lcsw_pkg::SAMPLE_W-1:0]   step_threshold,
   output logic                                 s1_valid,
   output lcsw_pkg::lcsw_info_type              s1_info,
   output logic [CAP_SUM_W-1:0]                 s1_total
);

   localparam int SW = lcsw_pkg::SAMPLE_W;
   localparam int TW = lcsw_pkg::TAP_SUM_W;
   localparam int PW = lcsw_pkg::TAP_PTR_W;

   logic [SW-1:0]         tap_ff [lcsw_pkg::FILTER_TAPS];
   logic [PW-1:0]         ptr_ff;
   logic [TW-1:0]         tap_sum_ff;
   logic [TW-1:0]         tap_sum_in;
   logic [SW-1:0]         last_avg_ff;
   logic [CAP_LEFT_W-1:0] cap_left_ff;
   logic [CAP_SUM_W-1:0]  cap_sum_ff;
   logic [SW-1:0]         baseline_ff;
   logic [SW-1:0]         held_avg_ff;
   logic [SW-1:0]         held_change_ff;

   logic                  s1_valid_ff;
   lcsw_pkg::lcsw_info_type s1_info_ff;
   logic [CAP_SUM_W-1:0]  s1_total_ff;

   logic [SW-1:0]         sample;
   logic                  capturing;
   logic                  cap_last;
   logic [CAP_SUM_W-1:0]  cap_total;
   logic [SW-1:0]         diff;
   logic [SW-1:0]         avg;
   logic                  trigger;

   // Per-request datapath
   always_comb begin
      sample     = raw_sample ^ lcsw_pkg::SIGN_FLIP;
      capturing  = (cap_left_ff != '0);
      cap_last   = (cap_left_ff == CAP_LEFT_W'(1));
      cap_total  = cap_sum_ff + CAP_SUM_W'(sample);
      diff       = lcsw_pkg::abs_diff(sample, last_avg_ff);
      tap_sum_in = tap_sum_ff - TW'(tap_ff[ptr_ff]) + TW'(sample);
      avg        = tap_sum_in[TW-1 -: SW];
      trigger    = (diff > step_threshold);
   end

   // Filter and capture state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lcsw_pkg::FILTER_TAPS; i++) begin
            tap_ff[i] <= '0;
         end
         ptr_ff         <= '0;
         tap_sum_ff     <= '0;
         last_avg_ff    <= '0;
         cap_left_ff    <= '0;
         cap_sum_ff     <= '0;
         baseline_ff    <= '0;
         held_avg_ff    <= '0;
         held_change_ff <= '0;
      end else if (accept) begin
         if (capturing) begin
            cap_left_ff <= cap_left_ff - CAP_LEFT_W'(1);
            cap_sum_ff  <= cap_last ? '0 : cap_total;
         end else begin
            tap_ff[ptr_ff] <= sample;
            ptr_ff         <= ptr_ff + PW'(1);
            tap_sum_ff     <= tap_sum_in;
            last_avg_ff    <= avg;
            if (trigger) begin
               baseline_ff    <= last_avg_ff;
               held_avg_ff    <= avg;
               held_change_ff <= diff;
               cap_left_ff    <= CAP_LEFT_W'(CAPTURE_SAMPLES);
               cap_sum_ff     <= '0;
            end
         end
      end
   end

   // Stage 1 valid: trigger and mid-capture requests give no response
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept && (capturing ? cap_last : !trigger);
      end
   end

   // Stage 1 payload
   always_ff @(posedge clock) begin
      if (advance) begin
         if (capturing) begin
            s1_info_ff.weighed  <= 1'b1;
            s1_info_ff.filtered <= held_avg_ff;
            s1_info_ff.change   <= held_change_ff;
            s1_info_ff.baseline <= baseline_ff;
         end else begin
            s1_info_ff.weighed  <= 1'b0;
            s1_info_ff.filtered <= avg;
            s1_info_ff.change   <= diff;
            s1_info_ff.baseline <= '0;
         end
         s1_total_ff <= cap_total;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_info  = s1_info_ff;
   assign s1_total = s1_total_ff;

endmodule

`default_nettype wire

/* rtl/lcsw_mean.sv */
// Capture mean: divide by the capture length with a split reciprocal multiply.
`default_nettype none

module lcsw_mean #(
   parameter int  CAPTURE_SAMPLES = lcsw_pkg::CAPTURE_SAMPLES,
   localparam int CAP_SUM_W       = lcsw_pkg::SAMPLE_W + $clog2(CAPTURE_SAMPLES + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          s1_valid,
   input  wire lcsw_pkg::lcsw_info_type       s1_info,
   input  wire logic [CAP_SUM_W-1:0]          s1_total,
   output logic                               s3_valid,
   output lcsw_pkg::lcsw_info_type            s3_info,
   output logic [lcsw_pkg::SAMPLE_W-1:0]      s3_mean
);

   // floor(x / N) = (x * ceil(2^K / N)) >> K, exact for x below 2^CAP_SUM_W
   localparam int DIV_L      = $clog2(CAPTURE_SAMPLES);
   localparam int DIV_K      = CAP_SUM_W + DIV_L;
   localparam int RECIP_W    = DIV_K + 1;
   localparam int RECIP_LO_W = (RECIP_W + 1) / 2;
   localparam int RECIP_HI_W = RECIP_W - RECIP_LO_W;
   localparam logic [63:0] RECIP =
      ((64'd1 << DIV_K) + 64'(CAPTURE_SAMPLES) - 64'd1) / 64'(CAPTURE_SAMPLES);
   localparam logic [RECIP_LO_W-1:0] RECIP_LO = RECIP[RECIP_LO_W-1:0];
   localparam logic [RECIP_HI_W-1:0] RECIP_HI = RECIP[RECIP_W-1:RECIP_LO_W];
   localparam int PROD_LO_W  = CAP_SUM_W + RECIP_LO_W;
   localparam int PROD_HI_W  = CAP_SUM_W + RECIP_HI_W;
   localparam int FULL_W     = CAP_SUM_W + RECIP_W;

   logic                    s2_valid_ff;
   lcsw_pkg::lcsw_info_type s2_info_ff;
   logic [PROD_LO_W-1:0]    prod_lo_ff;
   logic [PROD_HI_W-1:0]    prod_hi_ff;

   logic                    s3_valid_ff;
   lcsw_pkg::lcsw_info_type s3_info_ff;
   logic [lcsw_pkg::SAMPLE_W-1:0] s3_mean_ff;

   logic [FULL_W-1:0]       full;

   // Recombine the partial products
   always_comb begin
      full = (FULL_W'(prod_hi_ff) << RECIP_LO_W) + FULL_W'(prod_lo_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Stage 2: partial products; stage 3: quotient
   always_ff @(posedge clock) begin
      if (advance) begin
         s2_info_ff <= s1_info;
         prod_lo_ff <= PROD_LO_W'(s1_total) * PROD_LO_W'(RECIP_LO);
         prod_hi_ff <= PROD_HI_W'(s1_total) * PROD_HI_W'(RECIP_HI);
         s3_info_ff <= s2_info_ff;
         s3_mean_ff <= full[DIV_K +: lcsw_pkg::SAMPLE_W];
      end
   end

   assign s3_valid = s3_valid_ff;
   assign s3_info  = s3_info_ff;
   assign s3_mean  = s3_mean_ff;

endmodule

`default_nettype wire

/* rtl/lcsw_scale.sv */
// Step size, gain multiply, offset add with saturation, and the response register.
`default_nettype none

module lcsw_scale (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              advance,
   input  wire logic                              s3_valid,
   input  wire lcsw_pkg::lcsw_info_type           s3_info,
   input  wire logic [lcsw_pkg::SAMPLE_W-1:0]     s3_mean,
   input  wire logic [lcsw_pkg::GAIN_W-1:0]       weight_gain,
   input  wire logic [lcsw_pkg::OFFSET_W-1:0]     weight_offset,
   output logic                                   out_valid,
   output logic [lcsw_pkg::SAMPLE_W-1:0]          out_filtered,
   output logic [lcsw_pkg::SAMPLE_W-1:0]          out_change,
   output logic                                   out_weighed,
   output logic [lcsw_pkg::SAMPLE_W-1:0]          out_step_size,
   output logic [lcsw_pkg::WEIGHT_W-1:0]          out_weight
);

   localparam int SW     = lcsw_pkg::SAMPLE_W;
   localparam int CW     = lcsw_pkg::SCALED_W;
   localparam int WW     = lcsw_pkg::WEIGHT_W;
   localparam int TOTAL_W = CW + 2;

   logic                    s4_valid_ff;
   lcsw_pkg::lcsw_info_type s4_info_ff;
   logic [SW-1:0]           s4_step_ff;

   logic                    s5_valid_ff;
   lcsw_pkg::lcsw_info_type s5_info_ff;
   logic [SW-1:0]           s5_step_ff;
   logic [CW-1:0]           s5_scaled_ff;

   logic                    s6_valid_ff;
   lcsw_pkg::lcsw_info_type s6_info_ff;
   logic [SW-1:0]           s6_step_ff;
   logic [WW-1:0]           s6_weight_ff;

   logic [lcsw_pkg::PRODUCT_W-1:0] product;
   logic signed [TOTAL_W-1:0]      total;
   logic [WW-1:0]                  weight_sat;

   // Gain product and offset sum
   always_comb begin
      product = lcsw_pkg::PRODUCT_W'(weight_gain) * lcsw_pkg::PRODUCT_W'(s4_step_ff);
      total   = signed'({2'b00, s5_scaled_ff})
              + TOTAL_W'(signed'(weight_offset));
      // The sum never drops below the most negative offset, so only the top clips
      if (!total[TOTAL_W-1] && (total[TOTAL_W-2:WW-1] != '0)) begin
         weight_sat = lcsw_pkg::WEIGHT_MAX;
      end else begin
         weight_sat = total[WW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   // Stage 4: step size; stage 5: scaled gain; stage 6: response register
   always_ff @(posedge clock) begin
      if (advance) begin
         s4_info_ff   <= s3_info;
         s4_step_ff   <= s3_info.weighed ? lcsw_pkg::abs_diff(s3_mean, s3_info.baseline) : '0;
         s5_info_ff   <= s4_info_ff;
         s5_step_ff   <= s4_step_ff;
         s5_scaled_ff <= product[lcsw_pkg::PRODUCT_W-1:lcsw_pkg::GAIN_SHIFT];
         s6_info_ff   <= s5_info_ff;
         s6_step_ff   <= s5_step_ff;
         s6_weight_ff <= s5_info_ff.weighed ? weight_sat : '0;
      end
   end

   assign out_valid     = s6_valid_ff;
   assign out_filtered  = s6_info_ff.filtered;
   assign out_change    = s6_info_ff.change;
   assign out_weighed   = s6_info_ff.weighed;
   assign out_step_size = s6_step_ff;
   assign out_weight    = s6_weight_ff;

endmodule

`default_nettype wire

/* rtl/load_cell_step_weigher.sv */
// Load cell step weigher top level: registers, pipeline control and stage wiring.
//
// Requests carry one raw 24-bit converter word on req_raw_sample (req_valid /
// req_ready). Responses leave on the rsp_ channel (rsp_valid / rsp_ready) with
// the filtered average, the change, a weighed flag, the step size and the
// weight in 1/256 units. A request that crosses the step threshold gives no
// response; it starts a capture of the next CAPTURE_SAMPLES requests, of which
// only the last gives a response, the weighed one.
// An accepted request reaches rsp_valid through the stage 1 to 6 registers.
// One request is accepted every cycle while the response side keeps taking
// results; the six-stage pipeline (filter, two-part reciprocal divide, step,
// gain multiply, offset) moves as a whole.
// When rsp_valid is high and rsp_ready is low the whole pipeline holds and
// req_ready drops, so no response is lost.
// Reset clears the filter taps, the running sums, the capture state and all
// stage valid bits, and loads the register defaults (threshold 8000, gain
// 0.07963 in Q0.24, offset -700.3 in 1/256 units).
// csr_write_enable writes csr_write_data to the register at csr_index at once;
// index 0 is the step threshold, 1 the gain, 2 the offset, 3 is ignored.
`default_nettype none

module load_cell_step_weigher #(
   parameter int  CAPTURE_SAMPLES = lcsw_pkg::CAPTURE_SAMPLES,
   localparam int CAP_SUM_W       = lcsw_pkg::SAMPLE_W + $clog2(CAPTURE_SAMPLES + 1)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [lcsw_pkg::SAMPLE_W-1:0]       req_raw_sample,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [lcsw_pkg::SAMPLE_W-1:0]            rsp_filtered,
   output logic [lcsw_pkg::SAMPLE_W-1:0]            rsp_change,
   output logic                                     rsp_weighed,
   output logic [lcsw_pkg::SAMPLE_W-1:0]            rsp_step_size,
   output logic signed [lcsw_pkg::WEIGHT_W-1:0]     rsp_weight,
   input  wire logic                                csr_write_enable,
   input  wire logic [lcsw_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [lcsw_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   logic [lcsw_pkg::SAMPLE_W-1:0] threshold_ff;
   logic [lcsw_pkg::GAIN_W-1:0]   gain_ff;
   logic [lcsw_pkg::OFFSET_W-1:0] offset_ff;

   logic                          advance;
   logic                          accept;

   logic                          s1_valid;
   lcsw_pkg::lcsw_info_type       s1_info;
   logic [CAP_SUM_W-1:0]          s1_total;
   logic                          s3_valid;
   lcsw_pkg::lcsw_info_type       s3_info;
   logic [lcsw_pkg::SAMPLE_W-1:0] s3_mean;
   logic [lcsw_pkg::WEIGHT_W-1:0] weight;

   // Pipeline moves unless a finished response is waiting
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= lcsw_pkg::THRESHOLD_RESET;
         gain_ff      <= lcsw_pkg::GAIN_RESET;
         offset_ff    <= lcsw_pkg::OFFSET_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lcsw_pkg::CSR_STEP_THRESHOLD: begin
               threshold_ff <= csr_write_data[lcsw_pkg::SAMPLE_W-1:0];
            end
            lcsw_pkg::CSR_WEIGHT_GAIN: begin
               gain_ff <= csr_write_data[lcsw_pkg::GAIN_W-1:0];
            end
            lcsw_pkg::CSR_WEIGHT_OFFSET: begin
               offset_ff <= csr_write_data[lcsw_pkg::OFFSET_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   lcsw_filter #(
      .CAPTURE_SAMPLES (CAPTURE_SAMPLES)
   ) u_filter (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .accept         (accept),
      .raw_sample     (req_raw_sample),
      .step_threshold (threshold_ff),
      .s1_valid       (s1_valid),
      .s1_info        (s1_info),
      .s1_total       (s1_total)
   );

   lcsw_mean #(
      .CAPTURE_SAMPLES (CAPTURE_SAMPLES)
   ) u_mean (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .s1_valid (s1_valid),
      .s1_info  (s1_info),
      .s1_total (s1_total),
      .s3_valid (s3_valid),
      .s3_info  (s3_info),
      .s3_mean  (s3_mean)
   );

   lcsw_scale u_scale (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .s3_valid      (s3_valid),
      .s3_info       (s3_info),
      .s3_mean       (s3_mean),
      .weight_gain   (gain_ff),
      .weight_offset (offset_ff),
      .out_valid     (rsp_valid),
      .out_filtered  (rsp_filtered),
      .out_change    (rsp_change),
      .out_weighed   (rsp_weighed),
      .out_step_size (rsp_step_size),
      .out_weight    (weight)
   );

   assign rsp_weight = signed'(weight);

endmodule

`default_nettype wire

/* tb/load_cell_step_weigher_tb.sv */
// Self-checking testbench for the load cell step weigher: directed table, then random load steps.
module load_cell_step_weigher_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TAPS          = 16;
   localparam int CAPTURE_LEN   = 10;
   localparam logic [23:0] FLIP = 24'h800000;
   localparam longint WEIGHT_TOP = 64'sd2147483647;
   localparam logic [lcsw_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   localparam int IDLE_PCT      = 12;
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 300;

   // One result of the block, at port widths
   typedef struct packed {
      logic [23:0]        filtered;
      logic [23:0]        change;
      logic               weighed;
      logic [23:0]        step_size;
      logic signed [31:0] weight;
   } reading_type;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   // Directed row: a sample request or a register write; typed rows carry a hand-written result
   typedef struct packed {
      row_kind_type                     kind;
      logic [lcsw_pkg::CSR_INDEX_W-1:0] index;
      logic [lcsw_pkg::CSR_DATA_W-1:0]  data;
      logic [23:0]                      raw;
      logic                             typed;
      reading_type                      want;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 34;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // after reset: zero sample, then a change exactly at the threshold
      '{ROW_SAMPLE, '0, '0, 24'h800000, 1'b1, '{24'd0, 24'd0, 1'b0, 24'd0, 32'sd0}},
      '{ROW_SAMPLE, '0, '0, 24'h801F40, 1'b1, '{24'd500, 24'd8000, 1'b0, 24'd0, 32'sd0}},
      // one above the threshold: trigger, then a capture of extremes
      '{ROW_SAMPLE, '0, '0, 24'h802135, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 24'h7FFFFF, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 24'hFFFFFF, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 24'h000000, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 24'h800000, 1'b0, '0},
      // gain and offset rewritten mid-capture: closing weight saturates
      '{ROW_WRITE, lcsw_pkg::CSR_WEIGHT_GAIN, 25'h0FFFFFF, '0, 1'b0, '0},
      '{ROW_WRITE, lcsw_pkg::CSR_WEIGHT_OFFSET, 25'h0FFFFFF, '0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 24'h7FFFFF, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 24'h7FFFFF, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 24'h7FFFFF, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 24'h7FFFFF, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 24'h7FFFFF, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 24'h5A5A5A, 1'b0, '0},
      // zero threshold: equal sample passes, off by one triggers
      '{ROW_WRITE, lcsw_pkg::CSR_STEP_THRESHOLD, 25'd0, '0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 24'h800407, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 24'h800408, 1'b0, '0},
      // zero gain, lowest offset, and a write to the unused index, all mid-capture
      '{ROW_WRITE, lcsw_pkg::CSR_WEIGHT_GAIN, 25'd0, '0, 1'b0, '0},
      '{ROW_WRITE, lcsw_pkg::CSR_WEIGHT_OFFSET, 25'h1000000, '0, 1'b0, '0},
      '{ROW_WRITE, CSR_UNUSED, 25'h1FFFFFF, '0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 24'hA5A5A5, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 24'h123456, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 24'hFEDCBA, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 24'h000001, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 24'h7FFFFE, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 24'h800001, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 24'h3C3C3C, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 24'hC3C3C3, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 24'h0F0F0F, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 24'hF0F0F0, 1'b0, '0},
      // highest threshold: nothing triggers
      '{ROW_WRITE, lcsw_pkg::CSR_STEP_THRESHOLD, 25'h0FFFFFF, '0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 24'h7FFFFF, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 24'hFFFFFF, 1'b0, '0}
   };

   // Clock, reset and block ports
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid        = 1'b0;
   logic                              req_ready;
   logic [23:0]                       req_raw_sample   = '0;
   logic                              rsp_valid;
   logic                              rsp_ready        = 1'b0;
   logic [23:0]                       rsp_filtered;
   logic [23:0]                       rsp_change;
   logic                              rsp_weighed;
   logic [23:0]                       rsp_step_size;
   logic signed [31:0]                rsp_weight;
   logic                              csr_write_enable = 1'b0;
   logic [lcsw_pkg::CSR_INDEX_W-1:0]  csr_index        = '0;
   logic [lcsw_pkg::CSR_DATA_W-1:0]   csr_write_data   = '0;

   // Weigher model state and register copies
   logic [23:0]        taps [TAPS] = '{default: '0};
   logic [27:0]        tap_total     = '0;
   int                 tap_ptr       = 0;
   logic [23:0]        avg_now       = '0;
   int                 capture_left  = 0;
   logic [27:0]        capture_total = '0;
   logic [23:0]        base_level    = '0;
   logic [23:0]        held_avg      = '0;
   logic [23:0]        held_chg      = '0;
   logic [23:0]        thr_reg       = 24'd8000;
   logic [23:0]        gain_reg      = 24'd1335970;
   logic signed [24:0] offset_reg    = -25'sd179277;

   reading_type expected_readings [$];
   reading_type head;
   int          mismatch_count = 0;
   int          cycle_count    = 0;
   bit          idle_enable    = 1'b1;

   load_cell_step_weigher i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_raw_sample   (req_raw_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_filtered     (rsp_filtered),
      .rsp_change       (rsp_change),
      .rsp_weighed      (rsp_weighed),
      .rsp_step_size    (rsp_step_size),
      .rsp_weight       (rsp_weight),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [23:0] level_gap(input logic [23:0] a, input logic [23:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   // Advance the weigher model by one request; returns 1 when it yields a result
   function automatic logic weigh_step(input logic [23:0] raw, output reading_type r);
      logic [23:0] s;
      logic [23:0] prev;
      logic [23:0] gap;
      logic [23:0] mean;
      logic [47:0] product;
      longint      total;
      s = raw ^ FLIP;
      r = '0;
      // capture in progress: accumulate, close on the last sample
      if (capture_left != 0) begin
         capture_total = capture_total + s;
         capture_left  = capture_left - 1;
         if (capture_left != 0) begin
            return 1'b0;
         end
         mean    = 24'(capture_total / CAPTURE_LEN);
         gap     = level_gap(mean, base_level);
         product = 48'(gain_reg) * 48'(gap);
         total   = longint'(product >> 16) + longint'(offset_reg);
         if (total > WEIGHT_TOP) begin
            total = WEIGHT_TOP;
         end
         r.filtered    = held_avg;
         r.change      = held_chg;
         r.weighed     = 1'b1;
         r.step_size   = gap;
         r.weight      = 32'(total);
         capture_total = '0;
         return 1'b1;
      end
      // moving average update against the previous average
      prev          = avg_now;
      gap           = level_gap(s, prev);
      tap_total     = tap_total - taps[tap_ptr] + s;
      taps[tap_ptr] = s;
      tap_ptr       = (tap_ptr + 1) % TAPS;
      avg_now       = 24'(tap_total / TAPS);
      if (gap > thr_reg) begin
         base_level    = prev;
         held_avg      = avg_now;
         held_chg      = gap;
         capture_total = '0;
         capture_left  = CAPTURE_LEN;
         return 1'b0;
      end
      r.filtered = avg_now;
      r.change   = gap;
      return 1'b1;
   endfunction

   // Send one request, with random idle cycles ahead of it
   task automatic push_sample(input logic [23:0] raw, input logic typed,
                              input reading_type want);
      reading_type predicted;
      while (idle_enable && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_raw_sample <= raw;
      do @(posedge clock); while (!req_ready);
      if (weigh_step(raw, predicted)) begin
         expected_readings.push_back(typed ? want : predicted);
      end
   endtask

   task automatic write_register(input logic [lcsw_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [lcsw_pkg::CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         lcsw_pkg::CSR_STEP_THRESHOLD: thr_reg    = data[23:0];
         lcsw_pkg::CSR_WEIGHT_GAIN:    gain_reg   = data[23:0];
         lcsw_pkg::CSR_WEIGHT_OFFSET:  offset_reg = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Stop sending, wait for all results, then let a trigger still in flight settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Result side: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readings.size() == 0) begin
            $display("%0t: unexpected result: expected none, got filtered %0d change %0d %s",
                     $time, rsp_filtered, rsp_change,
                     $sformatf("weighed %0d step %0d weight %0d",
                               rsp_weighed, rsp_step_size, rsp_weight));
            mismatch_count++;
         end else begin
            head = expected_readings.pop_front();
            check_field("filtered", head.filtered, rsp_filtered);
            check_field("change", head.change, rsp_change);
            check_field("weighed", head.weighed, rsp_weighed);
            check_field("step_size", head.step_size, rsp_step_size);
            check_field("weight", longint'(head.weight), longint'(rsp_weight));
         end
      end
      rsp_ready <= !(idle_enable && $urandom_range(99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Stimulus
   initial begin
      logic [23:0]                     level;
      logic [23:0]                     s;
      logic [23:0]                     raw;
      logic [23:0]                     thr_next;
      logic [23:0]                     gain_next;
      logic [lcsw_pkg::CSR_DATA_W-1:0] offset_next;
      int unsigned                     amp;
      int unsigned                     roll;
      int                              delta;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            wait_idle();
            write_register(directed_rows[i].index, directed_rows[i].data);
         end else begin
            push_sample(directed_rows[i].raw, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // random phases, one register setting each; phase 1 runs without idling
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         idle_enable = (phase != 1);
         case (phase)
            0: begin
               thr_next    = 24'd8000;
               gain_next   = 24'd1335970;
               offset_next = 25'(-179277);
            end
            1: begin
               thr_next    = '0;
               gain_next   = 24'($urandom);
               offset_next = 25'($urandom);
            end
            2: begin
               thr_next    = '1;
               gain_next   = '1;
               offset_next = 25'h0FFFFFF;
            end
            3: begin
               thr_next    = 24'($urandom_range(100, 200000));
               gain_next   = 24'($urandom);
               offset_next = 25'($urandom);
            end
            4: begin
               thr_next    = 24'd8000;
               gain_next   = '1;
               offset_next = 25'h1000000;
            end
            default: begin
               thr_next    = 24'($urandom);
               gain_next   = 24'($urandom);
               offset_next = 25'($urandom);
            end
         endcase
         write_register(lcsw_pkg::CSR_STEP_THRESHOLD, 25'(thr_next));
         write_register(lcsw_pkg::CSR_WEIGHT_GAIN, 25'(gain_next));
         write_register(lcsw_pkg::CSR_WEIGHT_OFFSET, offset_next);

         // mostly a steady load with noise around the threshold, some load steps, some junk
         level = 24'($urandom);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(99);
            if (roll < 4) begin
               raw = 24'($urandom);
            end else begin
               if (roll < 12) begin
                  case ($urandom_range(3))
                     0:       level = '0;
                     1:       level = '1;
                     default: level = 24'($urandom);
                  endcase
               end
               amp = thr_reg >> 1;
               if ($urandom_range(3) == 0) begin
                  amp = thr_reg + (thr_reg >> 2);
               end
               delta = int'($urandom_range(2 * amp)) - int'(amp);
               s     = level + 24'(delta);
               raw   = s ^ FLIP;
            end
            push_sample(raw, 1'b0, '0);
         end
      end

      wait_idle();
      if (mismatch_count == 0 && expected_readings.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
